// ----- hdl/spq_pkg.sv -----
// shared types and constants for the sorted priority queue
`default_nettype none

package spq_pkg;

  localparam int unsigned DEPTH_DEF = 8;
  localparam int unsigned ElemW     = 32;
  localparam int unsigned PrioW     = 8;
  localparam int unsigned FillW     = 4;

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [ElemW-1:0] value;
    logic        [PrioW-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic             enq;
    logic             deq;
    logic [PrioW-1:0] prio;
    entry_t           new_entry;
  } op_t;

endpackage

`default_nettype wire

// ----- hdl/spq_cell.sv -----
// one slot of the sorted chain: compares, shifts toward tail on insert, toward head on remove
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire    clk_i,
  input  wire    rst_ni,
  input  op_t    op_i,
  input  wire    occ_i,
  input  entry_t left_i,
  input  wire    left_ins_i,
  input  entry_t right_i,
  output entry_t entry_o,
  output logic   ins_o
);

  entry_t entry_q;
  entry_t entry_d;
  logic   take_new;
  logic   take_left;

  // insert point or beyond: slot is empty or holds strictly lower priority
  assign ins_o     = !occ_i || (op_i.prio > entry_q.prio);
  assign take_new  = op_i.enq && ins_o && !left_ins_i;
  assign take_left = op_i.enq && ins_o && left_ins_i;

  always_comb begin
    entry_d = entry_q;
    if (op_i.deq) begin
      entry_d = right_i;
    end else if (take_new) begin
      entry_d = op_i.new_entry;
    end else if (take_left) begin
      entry_d = left_i;
    end
  end

  // payload only, occupancy comes from the count
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule

`default_nettype wire

// ----- hdl/sorted_priority_queue_top.sv -----
// Sorted priority queue, a chain of DEPTH compare-and-shift cells.
// The result beat appears in the cycle after the command is accepted.
// Throughput: one command per cycle; busy_o never rises, every cell updates each cycle.
// Reset clears the count and the result strobe; stored entries are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start_i,
  output logic                    busy_o,
  input  wire                     kind_i,
  input  wire signed [ElemW-1:0]  element_i,
  input  wire        [PrioW-1:0]  priority_req_i,
  output logic                    done_o,
  output logic       [1:0]        status_o,
  output logic signed [ElemW-1:0] out_element_o,
  output logic       [PrioW-1:0]  out_priority_o,
  output logic       [FillW-1:0]  fill_count_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]     count_q, count_d;
  logic                done_q;
  status_e             status_q, status_d;
  logic signed [ElemW-1:0] out_elem_q, out_elem_d;
  logic [PrioW-1:0]    out_prio_q, out_prio_d;
  logic [FillW-1:0]    fill_q;
  logic [CntW+FillW-1:0] count_ext;

  logic   accept;
  logic   is_enq, is_deq;
  logic   full, empty;
  op_t    op;
  entry_t ents [DEPTH];
  logic   ins  [DEPTH];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign is_enq = accept && (kind_e'(kind_i) == KIND_ENQ);
  assign is_deq = accept && (kind_e'(kind_i) == KIND_DEQ);
  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);

  always_comb begin
    op.enq             = is_enq && !full;
    op.deq             = is_deq && !empty;
    op.prio            = priority_req_i;
    op.new_entry.value = element_i;
    op.new_entry.prio  = priority_req_i;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   left_ins, occ;

    if (i == 0) begin : g_head
      assign left_ent = ents[i];
      assign left_ins = 1'b0;
    end else begin : g_mid
      assign left_ent = ents[i-1];
      assign left_ins = ins[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_ent = ents[i];
    end else begin : g_body
      assign right_ent = ents[i+1];
    end
    assign occ = (CntW'(i) < count_q);

    spq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .op_i      (op),
      .occ_i     (occ),
      .left_i    (left_ent),
      .left_ins_i(left_ins),
      .right_i   (right_ent),
      .entry_o   (ents[i]),
      .ins_o     (ins[i])
    );
  end

  always_comb begin
    count_d    = count_q;
    status_d   = ST_OK;
    out_elem_d = '0;
    out_prio_d = '0;
    if (is_enq) begin
      if (full) begin
        status_d = ST_OVERFLOW;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else if (is_deq) begin
      if (empty) begin
        status_d = ST_UNDERFLOW;
      end else begin
        count_d    = count_q - CntW'(1);
        out_elem_d = ents[0].value;
        out_prio_d = ents[0].prio;
      end
    end
  end

  assign count_ext = {{FillW{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q   <= status_d;
      out_elem_q <= out_elem_d;
      out_prio_q <= out_prio_d;
      fill_q     <= count_ext[FillW-1:0];
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_element_o  = out_elem_q;
  assign out_priority_o = out_prio_q;
  assign fill_count_o   = fill_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("count above depth");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (done_o == $past(start_i)))
    else $error("result beat without command");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_enq && full) |=> (done_o && status_o == ST_OVERFLOW && count_q == CntW'(DEPTH)))
    else $error("overflow not reported");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> (ents[0].prio >= ents[1].prio))
    else $error("head out of order");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_sorted_priority_queue_top.sv -----
// self-checking testbench for the sorted priority queue: directed and random commands against a behavioral queue

module tb_sorted_priority_queue_top;
  import spq_pkg::*;

  localparam int unsigned QDEPTH = DEPTH_DEF;
  localparam int unsigned NUM_RANDOM = 650;
  localparam int unsigned CALM_TAIL = 60;

  typedef struct {
    kind_e                   kind;
    logic signed [ElemW-1:0] element;
    logic        [PrioW-1:0] prio;
    bit                      drain_first;
  } cmd_t;

  typedef struct {
    status_e                 status;
    logic signed [ElemW-1:0] element;
    logic        [PrioW-1:0] prio;
    logic        [FillW-1:0] fill;
  } queue_result_t;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    start_i        = 1'b0;
  kind_e                   kind_i         = KIND_ENQ;
  logic signed [ElemW-1:0] element_i      = '0;
  logic        [PrioW-1:0] priority_req_i = '0;
  logic                    busy_o;
  logic                    done_o;
  logic        [1:0]       status_o;
  logic signed [ElemW-1:0] out_element_o;
  logic        [PrioW-1:0] out_priority_o;
  logic        [FillW-1:0] fill_count_o;

  cmd_t          cmd_q[$];
  queue_result_t due_results_q[$];
  int unsigned   issued_cnt  = 0;
  int unsigned   checked_cnt = 0;
  int unsigned   err_cnt     = 0;
  int unsigned   gap_left    = 0;

  // behavioral copy of the sorted store
  logic signed [ElemW-1:0] held_val[QDEPTH];
  logic        [PrioW-1:0] held_prio[QDEPTH];
  int unsigned             held_cnt = 0;

  sorted_priority_queue_top #(
    .DEPTH(QDEPTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .kind_i        (kind_i),
    .element_i     (element_i),
    .priority_req_i(priority_req_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .out_element_o (out_element_o),
    .out_priority_o(out_priority_o),
    .fill_count_o  (fill_count_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic queue_result_t apply_op(kind_e k, logic signed [ElemW-1:0] e,
                                             logic [PrioW-1:0] p);
    queue_result_t r;
    int unsigned   pos;
    r.status  = ST_OK;
    r.element = '0;
    r.prio    = '0;
    if (k == KIND_ENQ) begin
      if (held_cnt >= QDEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        pos = held_cnt;
        // only strictly lower priorities move back, so ties keep arrival order
        while (pos > 0 && p > held_prio[pos-1]) begin
          held_val[pos]  = held_val[pos-1];
          held_prio[pos] = held_prio[pos-1];
          pos--;
        end
        held_val[pos]  = e;
        held_prio[pos] = p;
        held_cnt++;
      end
    end else begin
      if (held_cnt == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        r.element = held_val[0];
        r.prio    = held_prio[0];
        for (pos = 1; pos < held_cnt; pos++) begin
          held_val[pos-1]  = held_val[pos];
          held_prio[pos-1] = held_prio[pos];
        end
        held_cnt--;
      end
    end
    r.fill = FillW'(held_cnt);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (err_cnt < 40) $display("[%0t] mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic add_cmd(kind_e k, logic signed [ElemW-1:0] e, logic [PrioW-1:0] p,
                         bit drain);
    cmd_t c;
    c.kind        = k;
    c.element     = e;
    c.prio        = p;
    c.drain_first = drain;
    cmd_q.push_back(c);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic accepted;
    logic go;
    cmd_t c;
    if (!rst_ni) begin
      start_i        <= 1'b0;
      kind_i         <= KIND_ENQ;
      element_i      <= '0;
      priority_req_i <= '0;
      gap_left       = 0;
    end else begin
      accepted = start_i && !busy_o;
      go       = 1'b0;
      if (accepted) begin
        due_results_q.push_back(apply_op(kind_i, element_i, priority_req_i));
        issued_cnt <= issued_cnt + 1;
      end
      if (accepted || !start_i) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_q.size() > 0) begin
          if (cmd_q[0].drain_first && (accepted || issued_cnt != checked_cnt)) begin
            go = 1'b0;
          end else if (cmd_q.size() > CALM_TAIL && $urandom_range(0, 4) == 0) begin
            gap_left = $urandom_range(0, 10);
          end else begin
            c              = cmd_q.pop_front();
            go             = 1'b1;
            kind_i         <= c.kind;
            element_i      <= c.element;
            priority_req_i <= c.prio;
          end
        end
        start_i <= go;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    queue_result_t want;
    if (!rst_ni) begin
      checked_cnt <= 0;
    end else if (done_o) begin
      if (checked_cnt >= issued_cnt) begin
        report_mismatch("result beat with no command outstanding");
      end else begin
        want = due_results_q.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("beat %0d status got %0d want %0d",
                                    checked_cnt, status_o, want.status));
        if (out_element_o !== want.element)
          report_mismatch($sformatf("beat %0d element got %0d want %0d",
                                    checked_cnt, out_element_o, want.element));
        if (out_priority_o !== want.prio)
          report_mismatch($sformatf("beat %0d priority got %0d want %0d",
                                    checked_cnt, out_priority_o, want.prio));
        if (fill_count_o !== want.fill)
          report_mismatch($sformatf("beat %0d fill got %0d want %0d",
                                    checked_cnt, fill_count_o, want.fill));
        checked_cnt <= checked_cnt + 1;
      end
    end
  end

  initial begin : stim_proc
    int unsigned phase_left;
    int unsigned enq_pct;
    logic [PrioW-1:0] p;
    kind_e k;
    phase_left = 0;
    enq_pct    = 50;

    // directed: underflow, ties, extremes, overflow, drain past empty
    add_cmd(KIND_DEQ, 32'sh7fffffff, 8'hff, 1'b0);
    add_cmd(KIND_ENQ, 32'sh80000000, 8'd0,   1'b0);
    add_cmd(KIND_ENQ, 32'sh7fffffff, 8'd255, 1'b0);
    add_cmd(KIND_ENQ, 32'sd11,       8'd7,   1'b0);
    add_cmd(KIND_ENQ, 32'sd12,       8'd7,   1'b0);
    add_cmd(KIND_ENQ, -32'sd1,       8'd255, 1'b0);
    add_cmd(KIND_ENQ, 32'sd0,        8'd7,   1'b0);
    add_cmd(KIND_ENQ, 32'sh55aa33cc, 8'd128, 1'b0);
    add_cmd(KIND_ENQ, 32'sh2a55cc33, 8'd0,   1'b0);
    add_cmd(KIND_ENQ, 32'sd99,       8'd255, 1'b1);
    add_cmd(KIND_ENQ, 32'sd100,      8'd0,   1'b0);
    for (int i = 0; i < QDEPTH + 1; i++) add_cmd(KIND_DEQ, '0, '0, 1'b0);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(15, 60);
        case ($urandom_range(0, 4))
          0: enq_pct = 5;
          1: enq_pct = 25;
          2: enq_pct = 50;
          3: enq_pct = 75;
          default: enq_pct = 95;
        endcase
      end
      phase_left--;
      k = ($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
      case ($urandom_range(0, 3))
        0: p = PrioW'($urandom());
        1: p = PrioW'($urandom_range(0, 3));
        2: p = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        default: p = PrioW'($urandom_range(100, 110));
      endcase
      add_cmd(k, $urandom(), p, (i == 0) || ($urandom_range(0, 63) == 0));
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_q.size() != 0 || start_i || issued_cnt != checked_cnt) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (err_cnt == 0 && due_results_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
